// ===== rtl/core/mvna_pkg.sv =====
// Shared types and constants of the vertex normal and area block.
`timescale 1ns / 1ps
package mvna_pkg;

  localparam int unsigned CW    = 24;        // coordinate width, Q15.8
  localparam int unsigned EW    = CW + 1;    // edge vector component width
  localparam int unsigned UW    = 16;        // unit component width, Q1.14
  localparam int unsigned SW    = 24;        // normal sum width
  localparam int unsigned CXW   = 2 * EW;    // raw edge cross component width
  localparam int unsigned HALFW = EW;        // split width for squaring |cross|
  localparam int unsigned OPW   = EW + 1;    // multiplier operand width
  localparam int unsigned PW    = 2 * OPW;   // product width
  localparam int unsigned ACCW  = PW + 2 * HALFW;  // accumulator width
  localparam int unsigned RADW  = 4 * HALFW;       // square root operand width
  localparam int unsigned ROOTW = 2 * HALFW;       // square root result width
  localparam int unsigned QW    = 16;        // quotient width
  localparam int unsigned NUMW  = 42;        // dividend width
  localparam int unsigned DENW  = EW + 1;    // divisor width
  localparam int unsigned AW    = 40;        // area width, Q32.8
  localparam int unsigned AREA_SHIFT = 9;    // half of the magnitude, Q.16 to Q.8
  localparam int unsigned ONE_Q14 = 16384;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VSQ,
    ST_VDR,
    ST_SQRT_GO,
    ST_SQRT_W,
    ST_DIV_GO,
    ST_DIV_W,
    ST_X0,
    ST_X1,
    ST_XDR,
    ST_XST,
    ST_CSQ,
    ST_CDR,
    ST_AREA,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    PH_E0,
    PH_E1,
    PH_XU,
    PH_XE,
    PH_AREA,
    PH_SUM
  } phase_e;

  typedef enum logic [1:0] {
    SH_0,
    SH_HALF1,
    SH_FULL
  } shift_e;

  typedef struct packed {
    logic signed [CW-1:0] prev_x;
    logic signed [CW-1:0] prev_y;
    logic signed [CW-1:0] prev_z;
    logic signed [CW-1:0] here_x;
    logic signed [CW-1:0] here_y;
    logic signed [CW-1:0] here_z;
    logic signed [CW-1:0] next_x;
    logic signed [CW-1:0] next_y;
    logic signed [CW-1:0] next_z;
    logic                 face_skipped;
    logic                 last_face;
  } in_req_t;

  typedef struct packed {
    logic signed [UW-1:0] normal_x;
    logic signed [UW-1:0] normal_y;
    logic signed [UW-1:0] normal_z;
    logic [AW-1:0]        area_sum;
  } out_req_t;

  typedef struct packed {
    logic                  vld;
    logic                  clr;
    logic                  sub;
    shift_e                sh;
    logic signed [OPW-1:0] a;
    logic signed [OPW-1:0] b;
  } mac_op_t;

endpackage

// ===== rtl/core/mvna_mac.sv =====
// Shared multiply-accumulate unit: registered product, then shifted add or subtract.
`timescale 1ns / 1ps
module mvna_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mvna_pkg::mac_op_t                     op_i,
  output logic signed [mvna_pkg::ACCW-1:0]      acc_o
);

  logic                                vld_q, clr_q, sub_q;
  mvna_pkg::shift_e                    sh_q;
  logic signed [mvna_pkg::PW-1:0]      prod_q;
  logic signed [mvna_pkg::ACCW-1:0]    acc_q, acc_d, ext, shifted, base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      clr_q <= 1'b0;
      sub_q <= 1'b0;
      sh_q  <= mvna_pkg::SH_0;
    end else begin
      vld_q <= op_i.vld;
      clr_q <= op_i.clr;
      sub_q <= op_i.sub;
      sh_q  <= op_i.sh;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mvna_pkg::PW'(op_i.a) * mvna_pkg::PW'(op_i.b);
    acc_q  <= acc_d;
  end

  always_comb begin
    ext = mvna_pkg::ACCW'(prod_q);
    case (sh_q)
      mvna_pkg::SH_0:     shifted = ext;
      mvna_pkg::SH_HALF1: shifted = ext <<< (mvna_pkg::HALFW + 1);
      mvna_pkg::SH_FULL:  shifted = ext <<< (2 * mvna_pkg::HALFW);
      default:            shifted = ext;
    endcase
    base  = clr_q ? '0 : acc_q;
    acc_d = acc_q;
    if (vld_q) begin
      acc_d = sub_q ? base - shifted : base + shifted;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/core/mvna_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module mvna_sqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [mvna_pkg::RADW-1:0]       rad_i,
  output logic                            done_o,
  output logic [mvna_pkg::ROOTW-1:0]      root_o
);

  localparam int unsigned REMW = mvna_pkg::ROOTW + 2;
  localparam int unsigned CNTW = $clog2(mvna_pkg::ROOTW);

  logic                          busy_q, done_q;
  logic [CNTW-1:0]               cnt_q;
  logic [mvna_pkg::RADW-1:0]     rad_q;
  logic [REMW-1:0]               rem_q, rem_d;
  logic [mvna_pkg::ROOTW-1:0]    root_q, root_d;
  logic [REMW+1:0]               rem_sh, trial;

  always_comb begin
    rem_sh = {rem_q, rad_q[mvna_pkg::RADW-1 -: 2]};
    trial  = (REMW + 2)'({root_q, 2'b01});
    if (rem_sh >= trial) begin
      rem_d  = REMW'(rem_sh - trial);
      root_d = {root_q[mvna_pkg::ROOTW-2:0], 1'b1};
    end else begin
      rem_d  = REMW'(rem_sh);
      root_d = {root_q[mvna_pkg::ROOTW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(mvna_pkg::ROOTW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/core/mvna_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mvna_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mvna_pkg::NUMW-1:0]      num_i,
  input  logic [mvna_pkg::DENW-1:0]      den_i,
  output logic                           done_o,
  output logic [mvna_pkg::QW-1:0]        quot_o
);

  localparam int unsigned CNTW = $clog2(mvna_pkg::QW);

  logic                          busy_q, done_q;
  logic [CNTW-1:0]               cnt_q;
  logic [mvna_pkg::NUMW-1:0]     rem_q, dsh;
  logic [mvna_pkg::DENW-1:0]     den_q;
  logic [mvna_pkg::QW-1:0]       quot_q;
  logic                          fit;

  assign dsh = mvna_pkg::NUMW'(den_q) << cnt_q;
  assign fit = rem_q >= dsh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(mvna_pkg::QW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      if (fit) rem_q <= rem_q - dsh;
      quot_q <= {quot_q[mvna_pkg::QW-2:0], fit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/core/mesh_vertex_normal_area.sv =====
// Top level: per-vertex normal and area accumulation with a shared arithmetic sequencer.
`timescale 1ns / 1ps
// One request per triangle around a vertex; the request flagged last_face
// produces one result with the unit vertex normal (Q1.14) and the summed
// triangle area (Q32.8, saturating), after which the sums are cleared.
// Skipped faces add nothing but a skipped last face still emits. The block
// takes one request at a time and is not ready while it works: a face needs
// a unit vector for both edges, each a square root and a division per component (none for a
// zero-length edge), then one more square root for the area, and a last face
// also the final normal. A skipped face that is not last leaves the block
// ready. Everything runs through one multiply-accumulate unit, one bit-serial
// square root and one bit-serial divider. A finished result sits in an output
// register, so the next face is taken while it waits; a new result waits only
// if the previous one is still held.
module mesh_vertex_normal_area (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mvna_pkg::in_req_t    in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mvna_pkg::out_req_t   out_req_o
);

  typedef logic signed [mvna_pkg::EW-1:0]  ecomp_t;
  typedef logic signed [mvna_pkg::UW-1:0]  ucomp_t;
  typedef logic signed [mvna_pkg::CXW-1:0] ccomp_t;
  typedef logic signed [mvna_pkg::SW-1:0]  scomp_t;

  // sequencer
  mvna_pkg::state_e state_q, state_d;
  mvna_pkg::phase_e phase_q, phase_d;
  logic [1:0]       idx_q, idx_d, part_q, part_d;
  logic             last_q;

  // working values
  ecomp_t e0_q [3];
  ecomp_t e1_q [3];
  ucomp_t u0_q [3];
  ucomp_t u1_q [3];
  ucomp_t nrm_q [3];
  ccomp_t c_q  [3];
  scomp_t sum_q [3];
  logic [mvna_pkg::AW-1:0]  area_q;
  logic [mvna_pkg::EW-1:0]  d_q;
  logic                     out_valid_q;
  mvna_pkg::out_req_t       out_q;

  // shared units
  mvna_pkg::mac_op_t                 mac_op;
  logic signed [mvna_pkg::ACCW-1:0]  acc;
  logic                              sqrt_start, sqrt_done;
  logic [mvna_pkg::ROOTW-1:0]        root;
  logic                              div_start, div_done;
  logic [mvna_pkg::NUMW-1:0]         div_num;
  logic [mvna_pkg::DENW-1:0]         div_den;
  logic [mvna_pkg::QW-1:0]           quot;

  logic   in_acc, unit_adv, out_load;
  ecomp_t vcomp;
  logic [mvna_pkg::EW-1:0] vabs;
  ucomp_t uval;
  logic [1:0] sel_a, sel_b;
  ucomp_t ua0, ub1, ub0, ua1;
  ecomp_t ea0, eb1, eb0, ea1;
  logic [mvna_pkg::CXW-1:0] cabs;
  logic signed [31:0] rsum;
  logic signed [17:0] rnd;
  logic signed [mvna_pkg::SW:0] nsum;
  scomp_t sum_new;
  logic [mvna_pkg::AW:0] face_area, area_tot;
  logic [mvna_pkg::AW-1:0] area_new;

  assign in_ready_o = (state_q == mvna_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == mvna_pkg::ST_OUT) && (!out_valid_q || out_ready_i);
  assign unit_adv   = ((state_q == mvna_pkg::ST_DIV_GO) && (d_q == '0))
                   || ((state_q == mvna_pkg::ST_DIV_W) && div_done);

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    idx_d   = idx_q;
    part_d  = part_q;
    case (state_q)
      mvna_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          idx_d  = '0;
          part_d = '0;
          if (!in_req_i.face_skipped) begin
            phase_d = mvna_pkg::PH_E0;
            state_d = mvna_pkg::ST_VSQ;
          end else if (in_req_i.last_face) begin
            phase_d = mvna_pkg::PH_SUM;
            state_d = mvna_pkg::ST_VSQ;
          end
        end
      end
      mvna_pkg::ST_VSQ: begin
        if (idx_q == 2'd2) begin
          idx_d   = '0;
          state_d = mvna_pkg::ST_VDR;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      mvna_pkg::ST_VDR:     state_d = mvna_pkg::ST_SQRT_GO;
      mvna_pkg::ST_SQRT_GO: state_d = mvna_pkg::ST_SQRT_W;
      mvna_pkg::ST_SQRT_W: begin
        if (sqrt_done) begin
          state_d = (phase_q == mvna_pkg::PH_AREA) ? mvna_pkg::ST_AREA
                                                   : mvna_pkg::ST_DIV_GO;
        end
      end
      mvna_pkg::ST_DIV_GO,
      mvna_pkg::ST_DIV_W: begin
        if (state_q == mvna_pkg::ST_DIV_GO && d_q != '0) begin
          state_d = mvna_pkg::ST_DIV_W;
        end else if (unit_adv) begin
          if (idx_q == 2'd2) begin
            idx_d = '0;
            case (phase_q)
              mvna_pkg::PH_E0: begin
                phase_d = mvna_pkg::PH_E1;
                state_d = mvna_pkg::ST_VSQ;
              end
              mvna_pkg::PH_E1: begin
                phase_d = mvna_pkg::PH_XU;
                state_d = mvna_pkg::ST_X0;
              end
              default: state_d = mvna_pkg::ST_OUT;
            endcase
          end else begin
            idx_d   = idx_q + 2'd1;
            state_d = mvna_pkg::ST_DIV_GO;
          end
        end
      end
      mvna_pkg::ST_X0:  state_d = mvna_pkg::ST_X1;
      mvna_pkg::ST_X1:  state_d = mvna_pkg::ST_XDR;
      mvna_pkg::ST_XDR: state_d = mvna_pkg::ST_XST;
      mvna_pkg::ST_XST: begin
        if (idx_q == 2'd2) begin
          idx_d = '0;
          if (phase_q == mvna_pkg::PH_XU) begin
            phase_d = mvna_pkg::PH_XE;
            state_d = mvna_pkg::ST_X0;
          end else begin
            phase_d = mvna_pkg::PH_AREA;
            part_d  = '0;
            state_d = mvna_pkg::ST_CSQ;
          end
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = mvna_pkg::ST_X0;
        end
      end
      mvna_pkg::ST_CSQ: begin
        if (part_q == 2'd2) begin
          part_d = '0;
          if (idx_q == 2'd2) begin
            idx_d   = '0;
            state_d = mvna_pkg::ST_CDR;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end else begin
          part_d = part_q + 2'd1;
        end
      end
      mvna_pkg::ST_CDR: state_d = mvna_pkg::ST_SQRT_GO;
      mvna_pkg::ST_AREA: begin
        if (last_q) begin
          phase_d = mvna_pkg::PH_SUM;
          idx_d   = '0;
          state_d = mvna_pkg::ST_VSQ;
        end else begin
          state_d = mvna_pkg::ST_IDLE;
        end
      end
      mvna_pkg::ST_OUT: if (out_load) state_d = mvna_pkg::ST_IDLE;
      default: state_d = mvna_pkg::ST_IDLE;
    endcase
  end

  // ---------------- datapath control ----------------
  // Cross component i: src0[a]*src1[b] - src0[b]*src1[a], a=i+1, b=i+2 mod 3.
  always_comb begin
    case (idx_q)
      2'd0:    begin sel_a = 2'd1; sel_b = 2'd2; end
      2'd1:    begin sel_a = 2'd2; sel_b = 2'd0; end
      default: begin sel_a = 2'd0; sel_b = 2'd1; end
    endcase
  end

  always_comb begin
    ua0 = u0_q[sel_a];
    ub0 = u0_q[sel_b];
    ua1 = u1_q[sel_a];
    ub1 = u1_q[sel_b];
    ea0 = e0_q[sel_a];
    eb0 = e0_q[sel_b];
    ea1 = e1_q[sel_a];
    eb1 = e1_q[sel_b];
    case (phase_q)
      mvna_pkg::PH_E0: vcomp = e0_q[idx_q];
      mvna_pkg::PH_E1: vcomp = e1_q[idx_q];
      default:         vcomp = mvna_pkg::EW'(sum_q[idx_q]);
    endcase
    vabs = vcomp[mvna_pkg::EW-1] ? mvna_pkg::EW'(-vcomp) : mvna_pkg::EW'(vcomp);
    cabs = c_q[idx_q][mvna_pkg::CXW-1] ? mvna_pkg::CXW'(-c_q[idx_q])
                                        : mvna_pkg::CXW'(c_q[idx_q]);
  end

  always_comb begin
    mac_op     = '0;
    mac_op.sh  = mvna_pkg::SH_0;
    sqrt_start = (state_q == mvna_pkg::ST_SQRT_GO);
    div_start  = (state_q == mvna_pkg::ST_DIV_GO) && (d_q != '0);
    // round(|v| * 2^14 / d) as floor((2|v|*2^14 + d) / 2d)
    div_num    = mvna_pkg::NUMW'({vabs, 15'b0}) + mvna_pkg::NUMW'(d_q);
    div_den    = {d_q, 1'b0};
    case (state_q)
      mvna_pkg::ST_VSQ: begin
        mac_op.vld = 1'b1;
        mac_op.clr = (idx_q == 2'd0);
        mac_op.a   = mvna_pkg::OPW'(vcomp);
        mac_op.b   = mvna_pkg::OPW'(vcomp);
      end
      mvna_pkg::ST_X0: begin
        mac_op.vld = 1'b1;
        mac_op.clr = 1'b1;
        mac_op.a   = (phase_q == mvna_pkg::PH_XU) ? mvna_pkg::OPW'(ua0)
                                                  : mvna_pkg::OPW'(ea0);
        mac_op.b   = (phase_q == mvna_pkg::PH_XU) ? mvna_pkg::OPW'(ub1)
                                                  : mvna_pkg::OPW'(eb1);
      end
      mvna_pkg::ST_X1: begin
        mac_op.vld = 1'b1;
        mac_op.sub = 1'b1;
        mac_op.a   = (phase_q == mvna_pkg::PH_XU) ? mvna_pkg::OPW'(ub0)
                                                  : mvna_pkg::OPW'(eb0);
        mac_op.b   = (phase_q == mvna_pkg::PH_XU) ? mvna_pkg::OPW'(ua1)
                                                  : mvna_pkg::OPW'(ea1);
      end
      mvna_pkg::ST_CSQ: begin
        // |c|^2 = hi^2 << 2H + 2*hi*lo << H + lo^2
        mac_op.vld = 1'b1;
        mac_op.clr = (idx_q == 2'd0) && (part_q == 2'd0);
        case (part_q)
          2'd0: begin
            mac_op.sh = mvna_pkg::SH_FULL;
            mac_op.a  = mvna_pkg::OPW'(cabs[mvna_pkg::CXW-1:mvna_pkg::HALFW]);
            mac_op.b  = mvna_pkg::OPW'(cabs[mvna_pkg::CXW-1:mvna_pkg::HALFW]);
          end
          2'd1: begin
            mac_op.sh = mvna_pkg::SH_HALF1;
            mac_op.a  = mvna_pkg::OPW'(cabs[mvna_pkg::CXW-1:mvna_pkg::HALFW]);
            mac_op.b  = mvna_pkg::OPW'(cabs[mvna_pkg::HALFW-1:0]);
          end
          default: begin
            mac_op.sh = mvna_pkg::SH_0;
            mac_op.a  = mvna_pkg::OPW'(cabs[mvna_pkg::HALFW-1:0]);
            mac_op.b  = mvna_pkg::OPW'(cabs[mvna_pkg::HALFW-1:0]);
          end
        endcase
      end
      default: ;
    endcase
  end

  // unit component from the divider, clamped to one, sign of the source component; zero for a zero divisor
  always_comb begin
    if (state_q == mvna_pkg::ST_DIV_GO) begin
      uval = '0;
    end else if (quot > mvna_pkg::QW'(mvna_pkg::ONE_Q14)) begin
      uval = vcomp[mvna_pkg::EW-1] ? -ucomp_t'(mvna_pkg::ONE_Q14)
                                   : ucomp_t'(mvna_pkg::ONE_Q14);
    end else begin
      uval = vcomp[mvna_pkg::EW-1] ? -ucomp_t'(quot) : ucomp_t'(quot);
    end
  end

  // Q2.28 -> Q1.14 half up, then saturating add into the normal sum
  always_comb begin
    rsum    = 32'(acc) + 32'sd8192;
    rnd     = rsum[31:14];
    nsum    = (mvna_pkg::SW + 1)'(sum_q[idx_q]) + (mvna_pkg::SW + 1)'(rnd);
    if (nsum[mvna_pkg::SW] != nsum[mvna_pkg::SW-1]) begin
      sum_new = nsum[mvna_pkg::SW] ? {1'b1, {(mvna_pkg::SW-1){1'b0}}}
                                   : {1'b0, {(mvna_pkg::SW-1){1'b1}}};
    end else begin
      sum_new = nsum[mvna_pkg::SW-1:0];
    end
    face_area = root[mvna_pkg::ROOTW-1:mvna_pkg::AREA_SHIFT];
    if (face_area[mvna_pkg::AW]) face_area = {1'b0, {mvna_pkg::AW{1'b1}}};
    area_tot  = {1'b0, area_q} + face_area;
    area_new  = area_tot[mvna_pkg::AW] ? '1 : area_tot[mvna_pkg::AW-1:0];
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mvna_pkg::ST_IDLE;
      phase_q     <= mvna_pkg::PH_E0;
      idx_q       <= '0;
      part_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      area_q      <= '0;
      for (int i = 0; i < 3; i++) sum_q[i] <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      part_q  <= part_d;
      if (in_acc) last_q <= in_req_i.last_face;
      if (state_q == mvna_pkg::ST_XST && phase_q == mvna_pkg::PH_XU) begin
        sum_q[idx_q] <= sum_new;
      end
      if (state_q == mvna_pkg::ST_AREA) area_q <= area_new;
      if (out_load) begin
        out_valid_q <= 1'b1;
        area_q      <= '0;
        for (int i = 0; i < 3; i++) sum_q[i] <= '0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e0_q[0] <= ecomp_t'(in_req_i.here_x) - ecomp_t'(in_req_i.prev_x);
      e0_q[1] <= ecomp_t'(in_req_i.here_y) - ecomp_t'(in_req_i.prev_y);
      e0_q[2] <= ecomp_t'(in_req_i.here_z) - ecomp_t'(in_req_i.prev_z);
      e1_q[0] <= ecomp_t'(in_req_i.next_x) - ecomp_t'(in_req_i.here_x);
      e1_q[1] <= ecomp_t'(in_req_i.next_y) - ecomp_t'(in_req_i.here_y);
      e1_q[2] <= ecomp_t'(in_req_i.next_z) - ecomp_t'(in_req_i.here_z);
    end
    if (sqrt_done && phase_q != mvna_pkg::PH_AREA) d_q <= root[mvna_pkg::EW-1:0];
    if (unit_adv) begin
      case (phase_q)
        mvna_pkg::PH_E0: u0_q[idx_q]  <= uval;
        mvna_pkg::PH_E1: u1_q[idx_q]  <= uval;
        default:         nrm_q[idx_q] <= uval;
      endcase
    end
    if (state_q == mvna_pkg::ST_XST && phase_q == mvna_pkg::PH_XE) begin
      c_q[idx_q] <= acc[mvna_pkg::CXW-1:0];
    end
    if (out_load) begin
      out_q.normal_x <= nrm_q[0];
      out_q.normal_y <= nrm_q[1];
      out_q.normal_z <= nrm_q[2];
      out_q.area_sum <= area_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // ---------------- shared units ----------------
  mvna_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .acc_o  (acc)
  );

  mvna_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (acc[mvna_pkg::RADW-1:0]),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  mvna_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

endmodule

// ===== verif/testbench.sv =====
// Testbench for mesh_vertex_normal_area: random and directed faces, scoreboard check.
`timescale 1ns / 1ps
module testbench;

  localparam int          RAND_ITEMS = 1500;
  localparam int          QUIET_FROM = 1350;   // no idling after this many requests
  localparam int          SETTLE     = 600;    // cycles after the last result
  localparam longint      LIMIT      = 4000000;
  localparam longint      AREA_TOP   = 64'hFF_FFFF_FFFF;
  localparam longint      NSUM_MAX   = 8388607;
  localparam longint      NSUM_MIN   = -8388608;
  localparam int          LONG_HOLD  = 3000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  mvna_pkg::in_req_t  in_req_i;
  logic               out_valid_o;
  logic               out_ready_i;
  mvna_pkg::out_req_t out_req_o;

  mesh_vertex_normal_area DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o)
  );

  // clock: 10 ns period
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // faces waiting to be sent, and vertex results still owed by the block
  mvna_pkg::in_req_t  face_q[$];
  mvna_pkg::out_req_t vertex_q[$];

  // running sums of the model, same meaning as in the block
  longint          nsum_x, nsum_y, nsum_z;
  longint unsigned area_total;

  int     errors;
  int     sent_cnt;
  int     done_cnt;
  bit     in_fired;
  int     in_gap;
  int     out_gap;
  int     hold_left;
  bit     hold_done;
  longint cycles;

  // floor(sqrt(s)) for s below 2^128
  function automatic logic [63:0] isqrt(input logic [127:0] s);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= s) r = c;
    end
    return r;
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // scale a vector to unit length in Q1.14, ties away from zero
  task automatic to_unit(input longint vx, input longint vy, input longint vz,
                         output longint ux, output longint uy, output longint uz);
    logic [127:0]    s;
    longint unsigned d;
    longint          v[3];
    longint          u[3];
    longint unsigned q;
    v[0] = vx;
    v[1] = vy;
    v[2] = vz;
    s = '0;
    for (int i = 0; i < 3; i++)
      s += {64'd0, mag(v[i])} * {64'd0, mag(v[i])};
    d = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      if (d == 0) begin
        u[i] = 0;
      end else begin
        q = (2 * mag(v[i]) * mvna_pkg::ONE_Q14 + d) / (2 * d);
        if (q > mvna_pkg::ONE_Q14) q = mvna_pkg::ONE_Q14;
        u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
    ux = u[0];
    uy = u[1];
    uz = u[2];
  endtask

  function automatic longint round_q14(input longint p);
    return (p + 8192) >>> 14;
  endfunction

  function automatic longint clamp_nsum(input longint v);
    if (v > NSUM_MAX) return NSUM_MAX;
    if (v < NSUM_MIN) return NSUM_MIN;
    return v;
  endfunction

  // fold one accepted face into the sums; queue the vertex result on last_face
  task automatic fold_face(input mvna_pkg::in_req_t f);
    longint             e0[3], e1[3], c[3];
    longint             a0, a1, a2, b0, b1, b2, nx, ny, nz;
    logic [127:0]       s;
    longint unsigned    face_area;
    mvna_pkg::out_req_t r;
    e0[0] = longint'(f.here_x) - longint'(f.prev_x);
    e0[1] = longint'(f.here_y) - longint'(f.prev_y);
    e0[2] = longint'(f.here_z) - longint'(f.prev_z);
    e1[0] = longint'(f.next_x) - longint'(f.here_x);
    e1[1] = longint'(f.next_y) - longint'(f.here_y);
    e1[2] = longint'(f.next_z) - longint'(f.here_z);
    if (!f.face_skipped) begin
      to_unit(e0[0], e0[1], e0[2], a0, a1, a2);
      to_unit(e1[0], e1[1], e1[2], b0, b1, b2);
      nsum_x = clamp_nsum(nsum_x + round_q14(a1 * b2 - b1 * a2));
      nsum_y = clamp_nsum(nsum_y + round_q14(b0 * a2 - a0 * b2));
      nsum_z = clamp_nsum(nsum_z + round_q14(a0 * b1 - b0 * a1));
      // area from the raw edges, exact
      c[0] = e0[1] * e1[2] - e1[1] * e0[2];
      c[1] = e1[0] * e0[2] - e0[0] * e1[2];
      c[2] = e0[0] * e1[1] - e1[0] * e0[1];
      s = '0;
      for (int i = 0; i < 3; i++)
        s += {64'd0, mag(c[i])} * {64'd0, mag(c[i])};
      face_area = isqrt(s) >> mvna_pkg::AREA_SHIFT;
      if (face_area > AREA_TOP) face_area = AREA_TOP;
      area_total += face_area;
      if (area_total > AREA_TOP) area_total = AREA_TOP;
    end
    if (f.last_face) begin
      to_unit(nsum_x, nsum_y, nsum_z, nx, ny, nz);
      r.normal_x = nx[mvna_pkg::UW-1:0];
      r.normal_y = ny[mvna_pkg::UW-1:0];
      r.normal_z = nz[mvna_pkg::UW-1:0];
      r.area_sum = area_total[mvna_pkg::AW-1:0];
      vertex_q.push_back(r);
      nsum_x     = 0;
      nsum_y     = 0;
      nsum_z     = 0;
      area_total = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // monitor: predict on accepted requests, compare accepted results
  always @(posedge clk_i) begin
    in_fired <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) fold_face(in_req_i);
      if (out_valid_o && out_ready_i) begin
        done_cnt++;
        if (vertex_q.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          errors++;
        end else begin
          if (out_req_o.normal_x !== vertex_q[0].normal_x)
            report_mismatch("normal_x", out_req_o.normal_x, vertex_q[0].normal_x);
          if (out_req_o.normal_y !== vertex_q[0].normal_y)
            report_mismatch("normal_y", out_req_o.normal_y, vertex_q[0].normal_y);
          if (out_req_o.normal_z !== vertex_q[0].normal_z)
            report_mismatch("normal_z", out_req_o.normal_z, vertex_q[0].normal_z);
          if (out_req_o.area_sum !== vertex_q[0].area_sum)
            report_mismatch("area_sum", out_req_o.area_sum, vertex_q[0].area_sum);
          void'(vertex_q.pop_front());
        end
      end
    end
  end

  // driver: offer queued faces, with random idle bursts
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fired)) begin
      if (in_gap > 0) begin
        in_gap     <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (face_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (sent_cnt < QUIET_FROM && $urandom_range(0, 7) == 0) begin
        in_gap     <= $urandom_range(0, 12);   // this cycle plus the rest of the burst
        in_valid_i <= 1'b0;
      end else begin
        in_req_i   <= face_q.pop_front();
        in_valid_i <= 1'b1;
        sent_cnt   <= sent_cnt + 1;
      end
    end
  end

  // result side: random stalls, plus one long hold that backs up the block
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (!hold_done && done_cnt >= 40) begin
        hold_done   <= 1'b1;
        hold_left   <= LONG_HOLD;
        out_ready_i <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap     <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else if (sent_cnt < QUIET_FROM && $urandom_range(0, 5) == 0) begin
        out_gap     <= $urandom_range(0, 12);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic mvna_pkg::in_req_t make_face(
      input longint px, input longint py, input longint pz,
      input longint hx, input longint hy, input longint hz,
      input longint nx, input longint ny, input longint nz,
      input bit skip, input bit last);
    mvna_pkg::in_req_t f;
    f.prev_x = px[mvna_pkg::CW-1:0];
    f.prev_y = py[mvna_pkg::CW-1:0];
    f.prev_z = pz[mvna_pkg::CW-1:0];
    f.here_x = hx[mvna_pkg::CW-1:0];
    f.here_y = hy[mvna_pkg::CW-1:0];
    f.here_z = hz[mvna_pkg::CW-1:0];
    f.next_x = nx[mvna_pkg::CW-1:0];
    f.next_y = ny[mvna_pkg::CW-1:0];
    f.next_z = nz[mvna_pkg::CW-1:0];
    f.face_skipped = skip;
    f.last_face    = last;
    return f;
  endfunction

  // a coordinate: full range, or near the base so edges stay modest
  function automatic logic [mvna_pkg::CW-1:0] pick_coord(input int style,
                                                         input logic [mvna_pkg::CW-1:0] base);
    case (style)
      0:       return mvna_pkg::CW'($urandom);
      1:       return base + mvna_pkg::CW'($urandom_range(0, 2000)) - mvna_pkg::CW'(1000);
      default: return base + mvna_pkg::CW'($urandom_range(0, 60)) - mvna_pkg::CW'(30);
    endcase
  endfunction

  task automatic wait_drained();
    while (face_q.size() != 0 || in_valid_i || vertex_q.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    mvna_pkg::in_req_t         f;
    int                        nf;
    int                        style;
    logic [mvna_pkg::CW-1:0]   hx, hy, hz;
    longint                    mx, mn;
    logic [223:0]              noise;
    errors      = 0;
    sent_cnt    = 0;
    done_cnt    = 0;
    cycles      = 0;
    in_gap      = 0;
    out_gap     = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    nsum_x      = 0;
    nsum_y      = 0;
    nsum_z      = 0;
    area_total  = 0;
    in_fired    = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_ready_i = 1'b0;
    rst_ni      = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    mx = 8388607;
    mn = -8388608;
    // last flag with nothing accumulated: zero normal, zero area
    face_q.push_back(make_face(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
    // simple unit triangle in the xy plane
    face_q.push_back(make_face(0, 0, 0, 256, 0, 0, 256, 256, 0, 1'b0, 1'b1));
    // zero edge from prev to here, then zero edge from here to next
    face_q.push_back(make_face(100, 200, 300, 100, 200, 300, 500, -70, 9, 1'b0, 1'b0));
    face_q.push_back(make_face(5, 6, 7, -900, 40, 2, -900, 40, 2, 1'b0, 1'b1));
    // one plain face, then skipped faces, the last one also skipped
    face_q.push_back(make_face(0, 0, 0, 0, 1000, 0, 0, 0, 1000, 1'b0, 1'b0));
    face_q.push_back(make_face(mn, mn, mn, mx, mx, mx, mn, mx, mn, 1'b1, 1'b0));
    face_q.push_back(make_face(mx, 0, mn, 0, 0, 0, mn, 0, mx, 1'b1, 1'b1));
    // opposite faces cancel: zero summed normal with nonzero area
    face_q.push_back(make_face(0, 0, 0, 512, 0, 0, 512, 512, 0, 1'b0, 1'b0));
    face_q.push_back(make_face(0, 0, 0, 512, 0, 0, 512, -512, 0, 1'b0, 1'b1));
    // extreme corners
    face_q.push_back(make_face(mn, mn, mn, mx, mx, mx, mn, mx, mx, 1'b0, 1'b0));
    face_q.push_back(make_face(mx, mn, mx, mn, mx, mn, mx, mx, mn, 1'b0, 1'b1));
    // huge triangles: area accumulator saturates
    for (int i = 0; i < 4; i++)
      face_q.push_back(make_face(mn, 0, 0, mx, mn, 0, mx, mx, 0, 1'b0, i == 3));
    // all-ones and all-zero field patterns
    face_q.push_back(make_face(-1, -1, -1, 0, 0, 0, -1, 0, -1, 1'b0, 1'b1));
    face_q.push_back(make_face(mn, mn, mn, mn, mn, mn, mx, mx, mx, 1'b0, 1'b1));
    wait_drained();   // sender pause with nothing outstanding

    // random vertices: mostly well-formed fans, some noise
    while (face_q.size() < RAND_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        f = noise[$bits(mvna_pkg::in_req_t)-1:0];
        face_q.push_back(f);
      end else begin
        nf    = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
        style = $urandom_range(0, 3);
        hx    = mvna_pkg::CW'($urandom);
        hy    = mvna_pkg::CW'($urandom);
        hz    = mvna_pkg::CW'($urandom);
        for (int i = 0; i < nf; i++) begin
          f.here_x = hx;
          f.here_y = hy;
          f.here_z = hz;
          f.prev_x = pick_coord(style, hx);
          f.prev_y = pick_coord(style, hy);
          f.prev_z = pick_coord(style, hz);
          f.next_x = pick_coord(style, hx);
          f.next_y = pick_coord(style, hy);
          f.next_z = pick_coord(style, hz);
          if ($urandom_range(0, 19) == 0) begin
            f.prev_x = hx;
            f.prev_y = hy;
            f.prev_z = hz;
          end
          f.face_skipped = ($urandom_range(0, 9) == 0);
          f.last_face    = (i == nf - 1);
          face_q.push_back(f);
        end
      end
    end
    // close any fan left open by noise
    face_q.push_back(make_face(1, 2, 3, 4, 5, 6, 7, 8, 0, 1'b0, 1'b1));
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);

    if (errors == 0 && vertex_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
